>>> rtl/bfp2tu_pkg.sv
// ----------------------------------------------------------------------------
// bfp2tu_pkg: shared types and constants for the BFP2 tile unpacker
// Element geometry, exponent store shape, register indexes and the beat
// passed from the staging register to the element serializer.
// ----------------------------------------------------------------------------
package bfp2tu_pkg;

   localparam int ELEMS_PER_WORD = 16;
   localparam int ELEM_BITS      = 4;
   localparam int FACE_DIM       = 16;
   localparam int STORE_DEPTH    = 64;
   localparam int STORE_ROWS     = STORE_DEPTH / 4;
   localparam int ROW_BITS       = 4;
   localparam int REBIAS         = 112;
   localparam int POS_BITS       = 10;
   localparam int K_BITS         = 8;
   localparam int MANT_BITS      = 23;

   localparam int EXP_WORDS_DEF  = 16;
   localparam int DATA_WORDS_DEF = 64;
   localparam int TILE_COLS_DEF  = 32;

   localparam logic REG_EXP_REBIAS = 1'b0;
   localparam logic REG_ROW_MAJOR  = 1'b1;

   typedef struct packed {
      logic [31:0]       word;
      logic [7:0]        exp_byte;
      logic [K_BITS-1:0] k;
   } beat_type;

endpackage

>>> rtl/bfp2_tile_unpack.sv
// ----------------------------------------------------------------------------
// bfp2_tile_unpack: BFP2 tile to FP32 element unpacker
// Exponent words fill a shared exponent memory; each data word expands into
// sixteen FP32 elements with their tile positions.
// ----------------------------------------------------------------------------
// An exponent word writes one row of the exponent memory.
// A data word reads its exponent row in the cycle it is accepted and then
// occupies the element serializer for sixteen elements, one element per
// beat, so that serializer sets the sustained rate of data words. A staging
// register takes the next word while the current one drains. The exponent
// memory needs no clearing after reset.
module bfp2_tile_unpack #(
   parameter int EXP_WORDS  = bfp2tu_pkg::EXP_WORDS_DEF,
   parameter int DATA_WORDS = bfp2tu_pkg::DATA_WORDS_DEF,
   parameter int TILE_COLS  = bfp2tu_pkg::TILE_COLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] tile_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [31:0] float_bits, [41:32] element_position
   output logic        rsp_tuser,    // [0] last_of_word
   output logic        rsp_tlast,    // last_of_tile
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bfp2tu_pkg::*;

   localparam int TOTAL = EXP_WORDS + DATA_WORDS;
   localparam int CW    = $clog2(TOTAL);

   logic [CW-1:0]     word_cnt_ff, word_cnt_in;
   logic              rebias_ff, row_major_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic [31:0]       s1_word_ff;
   logic [K_BITS-1:0] s1_k_ff;
   logic [1:0]        s1_byte_ff;

   logic              req_accept;
   logic              csr_write;
   logic [8:0]        pos_ext;
   logic [8:0]        k_ext;
   logic              is_exp;
   logic              wr_en;
   logic              rd_en;
   logic [31:0]       rd_row_data;
   beat_type          beat;
   logic              beat_take;
   logic [31:0]       float_bits;
   logic [POS_BITS-1:0] element_position;

   assign req_tready = !s1_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign pos_ext    = 9'(word_cnt_ff);
   assign k_ext      = pos_ext - 9'(EXP_WORDS);
   assign is_exp     = (pos_ext < 9'(EXP_WORDS));
   assign wr_en      = req_accept && is_exp && (pos_ext < 9'(STORE_ROWS));
   assign rd_en      = req_accept && !is_exp;

   assign word_cnt_in = (word_cnt_ff == CW'(TOTAL - 1)) ? '0 : word_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_cnt_ff <= '0;
      end else if (req_accept) begin
         word_cnt_ff <= word_cnt_in;
      end
   end

   bfp2tu_exp_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (pos_ext[ROW_BITS-1:0]),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_row  (k_ext[ROW_BITS+1:2]),
      .rd_data (rd_row_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (beat_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_word_ff <= req_tdata;
         s1_k_ff    <= k_ext[K_BITS-1:0];
         s1_byte_ff <= k_ext[1:0];
      end
   end

   assign beat.word     = s1_word_ff;
   assign beat.exp_byte = rd_row_data[{s1_byte_ff, 3'b000} +: 8];
   assign beat.k        = s1_k_ff;

   bfp2tu_emitter #(
      .DATA_WORDS (DATA_WORDS),
      .TILE_COLS  (TILE_COLS)
   ) u_emitter (
      .clock            (clock),
      .reset            (reset),
      .beat_valid       (s1_valid_ff),
      .beat             (beat),
      .exp_a_rebias     (rebias_ff),
      .row_major_order  (row_major_ff),
      .beat_take        (beat_take),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .float_bits       (float_bits),
      .element_position (element_position),
      .last_of_word     (rsp_tuser),
      .last_of_tile     (rsp_tlast)
   );

   assign rsp_tdata = {6'b000000, element_position, float_bits};

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rebias_ff    <= 1'b0;
         row_major_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_EXP_REBIAS: rebias_ff    <= csr_pwdata[0];
            REG_ROW_MAJOR:  row_major_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_EXP_REBIAS: csr_prdata = {31'd0, rebias_ff};
         REG_ROW_MAJOR:  csr_prdata = {31'd0, row_major_ff};
         default:        csr_prdata = '0;
      endcase
   end

   a_stage_fill: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_valid_ff && !req_tready)
      else $error("staging register not filled after data beat");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      word_cnt_ff <= CW'(TOTAL - 1))
      else $error("word counter out of range");

   a_tile_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("tile end not on a word end");

endmodule

>>> rtl/bfp2tu_exp_store.sv
// ----------------------------------------------------------------------------
// bfp2tu_exp_store: shared exponent memory
// Sixteen rows of four exponent bytes, one row written per exponent word,
// one row read per data word with registered read data.
// ----------------------------------------------------------------------------
module bfp2tu_exp_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [bfp2tu_pkg::ROW_BITS-1:0] wr_row,
   input  logic [31:0]                   wr_data,
   input  logic                          rd_en,
   input  logic [bfp2tu_pkg::ROW_BITS-1:0] rd_row,
   output logic [31:0]                   rd_data
);
   import bfp2tu_pkg::*;

   logic [31:0] mem [STORE_ROWS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bfp2tu_emitter.sv
// ----------------------------------------------------------------------------
// bfp2tu_emitter: element serializer
// Holds one data word with its exponent and position base and sends out
// one FP32 element per beat, sixteen beats per word.
// ----------------------------------------------------------------------------
module bfp2tu_emitter #(
   parameter int DATA_WORDS = bfp2tu_pkg::DATA_WORDS_DEF,
   parameter int TILE_COLS  = bfp2tu_pkg::TILE_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           beat_valid,
   input  bfp2tu_pkg::beat_type           beat,
   input  logic                           exp_a_rebias,
   input  logic                           row_major_order,
   output logic                           beat_take,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [31:0]                    float_bits,
   output logic [bfp2tu_pkg::POS_BITS-1:0] element_position,
   output logic                           last_of_word,
   output logic                           last_of_tile
);
   import bfp2tu_pkg::*;

   localparam int FPR = (TILE_COLS / FACE_DIM > 0) ? TILE_COLS / FACE_DIM : 1;

   logic                 em_valid_ff, em_valid_in;
   logic [ELEM_BITS-1:0] em_elem_ff, em_elem_in;
   logic [31:0]          em_word_ff;
   logic [8:0]           em_exp_ff;
   logic [POS_BITS-1:0]  em_base_ff;
   logic                 em_klast_ff;

   logic                 em_last;
   logic [3:0]           face;
   logic [3:0]           face_col;
   logic [3:0]           face_row;
   logic [7:0]           tile_row;
   logic [POS_BITS-1:0]  base_rm;
   logic [POS_BITS-1:0]  base_face;
   logic [8:0]           exp_next;
   logic [1:0]           pair;

   assign em_last   = (em_elem_ff == ELEM_BITS'(ELEMS_PER_WORD - 1));
   assign beat_take = beat_valid && (!em_valid_ff || (em_last && out_ready));

   always_comb begin
      face      = beat.k[7:4];
      face_col  = 4'(face % FPR);
      face_row  = 4'(face / FPR);
      tile_row  = {face_row, beat.k[3:0]};
      base_rm   = POS_BITS'(32'(face_col) * FACE_DIM + TILE_COLS * 32'(tile_row));
      base_face = {beat.k[5:0], 4'b0000};
      exp_next  = {1'b0, beat.exp_byte} + (exp_a_rebias ? 9'(REBIAS) : 9'd0);
   end

   always_comb begin
      em_valid_in = em_valid_ff;
      em_elem_in  = em_elem_ff;
      if (beat_take) begin
         em_valid_in = 1'b1;
         em_elem_in  = '0;
      end else if (em_valid_ff && out_ready) begin
         em_elem_in = em_elem_ff + 1'b1;
         if (em_last) begin
            em_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         em_elem_ff  <= '0;
      end else begin
         em_valid_ff <= em_valid_in;
         em_elem_ff  <= em_elem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_take) begin
         em_word_ff  <= beat.word;
         em_exp_ff   <= exp_next;
         em_base_ff  <= row_major_order ? base_rm : base_face;
         em_klast_ff <= (beat.k == K_BITS'(DATA_WORDS - 1));
      end
   end

   assign pair             = em_word_ff[{em_elem_ff, 1'b0} +: 2];
   assign out_valid        = em_valid_ff;
   assign float_bits       = {pair[1] | (pair[0] & em_exp_ff[8]),
                              pair[0] ? em_exp_ff[7:0] : 8'd0,
                              {MANT_BITS{1'b0}}};
   assign element_position = em_base_ff + POS_BITS'(em_elem_ff);
   assign last_of_word     = em_last;
   assign last_of_tile     = em_last && em_klast_ff;

endmodule
